>>> rtl/sha_pkg.sv
`default_nettype none

package sha_pkg;

   typedef logic [31:0] word_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_RUN,
      ST_FOLD,
      ST_OUT
   } state_type;

   // controls from the sequencer to the message buffer
   typedef struct packed {
      logic wr_byte;   // write one message byte at pos
      logic pad;       // apply padding for this block
      logic pad_zero;  // padding block holds no 0x80 marker (second pad block)
      logic put_len;   // place bit length in the last two words
      logic shift;     // advance the message schedule one round
   } msg_ctl_type;

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LEN_POS = 6'd55;
   localparam logic [1:0] LAST_IDX = 2'd3;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // rotate right by a constant amount
   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

`default_nettype wire

>>> rtl/sha_msg.sv
`default_nettype none

// Block buffer that doubles as the message schedule window.
module sha_msg (
   input  wire logic                clock,
   input  wire sha_pkg::msg_ctl_type ctl,
   input  wire logic [5:0]          pos,
   input  wire logic [7:0]          data_byte,
   input  wire logic [63:0]         bit_len,
   output sha_pkg::word_type        w_out
);

   sha_pkg::word_type w_ff [16];
   sha_pkg::word_type s0;
   sha_pkg::word_type s1;
   sha_pkg::word_type w_new;

   // next schedule word from the sliding window
   always_comb begin
      s0 = sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
   end

   assign w_out = w_ff[0];

   always_ff @(posedge clock) begin
      if (ctl.wr_byte) begin
         w_ff[pos[5:2]][(5'd24 - {pos[1:0], 3'b000}) +: 8] <= data_byte;
      end
      if (ctl.pad) begin
         // marker at pos, zeros behind it; whole block zero for a second pad block
         for (int p = 0; p < 64; p++) begin
            if (ctl.pad_zero || (p[5:0] > pos)) begin
               w_ff[p[5:2]][(5'd24 - {p[1:0], 3'b000}) +: 8] <= 8'h00;
            end else if (p[5:0] == pos) begin
               w_ff[p[5:2]][(5'd24 - {p[1:0], 3'b000}) +: 8] <= sha_pkg::PAD_MARKER;
            end
         end
         if (ctl.put_len) begin
            w_ff[14] <= bit_len[63:32];
            w_ff[15] <= bit_len[31:0];
         end
      end
      if (ctl.shift) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_new;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sha_round.sv
`default_nettype none

// Working variables a..h and the shared round unit, one round per cycle while step is high.
module sha_round (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic              step,
   input  wire sha_pkg::word_type chain_in [8],
   input  wire sha_pkg::word_type k_in,
   input  wire sha_pkg::word_type w_in,
   output sha_pkg::word_type      work_out [8]
);

   sha_pkg::word_type work_ff [8];
   sha_pkg::word_type big0;
   sha_pkg::word_type big1;
   sha_pkg::word_type ch;
   sha_pkg::word_type maj;
   sha_pkg::word_type t1;
   sha_pkg::word_type t2;

   // round function
   always_comb begin
      big1 = sha_pkg::rotr(work_ff[4], 6) ^ sha_pkg::rotr(work_ff[4], 11) ^
             sha_pkg::rotr(work_ff[4], 25);
      ch = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1 = work_ff[7] + big1 + ch + k_in + w_in;
      big0 = sha_pkg::rotr(work_ff[0], 2) ^ sha_pkg::rotr(work_ff[0], 13) ^
             sha_pkg::rotr(work_ff[0], 22);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
            (work_ff[1] & work_ff[2]);
      t2 = big0 + maj;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= chain_in;
      end else if (step) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
   end

   assign work_out = work_ff;

endmodule

`default_nettype wire

>>> rtl/sha256_byte_stream_hasher.sv
// Sequence: a byte that does not fill a block is just written; one that fills it
//   then starts load, 64 rounds of the shared round unit, and fold.
// Final word: that, then a pad, load, rounds and fold pass per padding block (two
//   when 56 or more bytes are buffered), then 4 digest words, one per cycle as the
//   consumer takes them. No byte is taken while a block is hashed.
// Reset: synchronous; chaining value to the initial hash, byte count to zero.
`default_nettype none

module sha256_byte_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_is_final,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_word,
   output logic [1:0]       rsp_word_index,
   output logic             rsp_last_word
);

   sha_pkg::state_type   state_ff;
   sha_pkg::state_type   state_in;
   sha_pkg::word_type    chain_ff [8];
   sha_pkg::word_type    work [8];
   sha_pkg::word_type    w_cur;
   sha_pkg::msg_ctl_type msg_ctl;
   logic [60:0]          count_ff;
   logic [5:0]           round_ff;
   logic [1:0]           idx_ff;
   logic                 fin_ff;
   logic                 last_blk_ff;
   logic                 second_ff;
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 blk_full;
   logic                 pad_last;
   logic                 load;
   logic                 step;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign blk_full = req_has_byte && (count_ff[5:0] == sha_pkg::LAST_POS);
   // this padding block carries the length
   assign pad_last = second_ff || (count_ff[5:0] <= sha_pkg::LEN_POS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (blk_full) begin
                  state_in = sha_pkg::ST_LOAD;
               end else if (req_is_final) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_PAD:  state_in = sha_pkg::ST_LOAD;
         sha_pkg::ST_LOAD: state_in = sha_pkg::ST_RUN;
         sha_pkg::ST_RUN: begin
            if (round_ff == sha_pkg::LAST_POS) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            priority if (!fin_ff) begin
               state_in = sha_pkg::ST_IDLE;
            end else if (last_blk_ff) begin
               state_in = sha_pkg::ST_OUT;
            end else begin
               state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_OUT: begin
            if (rsp_fire && (idx_ff == sha_pkg::LAST_IDX)) begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_ready = (state_ff == sha_pkg::ST_IDLE);
      rsp_valid = (state_ff == sha_pkg::ST_OUT);
      load = (state_ff == sha_pkg::ST_LOAD);
      step = (state_ff == sha_pkg::ST_RUN);
      msg_ctl.wr_byte = req_fire && req_has_byte;
      msg_ctl.pad = (state_ff == sha_pkg::ST_PAD);
      msg_ctl.pad_zero = second_ff;
      msg_ctl.put_len = pad_last;
      msg_ctl.shift = step;
   end

   sha_msg u_msg (
      .clock     (clock),
      .ctl       (msg_ctl),
      .pos       (count_ff[5:0]),
      .data_byte (req_data_byte),
      .bit_len   ({count_ff, 3'b000}),
      .w_out     (w_cur)
   );

   sha_round u_round (
      .clock    (clock),
      .load     (load),
      .step     (step),
      .chain_in (chain_ff),
      .k_in     (sha_pkg::ROUND_K[round_ff]),
      .w_in     (w_cur),
      .work_out (work)
   );

   // sequencer registers, count and chaining value
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         chain_ff <= sha_pkg::INIT_HASH;
         count_ff <= '0;
         round_ff <= '0;
         idx_ff <= '0;
         fin_ff <= 1'b0;
         last_blk_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            fin_ff <= req_is_final;
            last_blk_ff <= 1'b0;
            second_ff <= 1'b0;
            if (req_has_byte) begin
               count_ff <= count_ff + 61'd1;
            end
         end
         if (state_ff == sha_pkg::ST_PAD) begin
            last_blk_ff <= pad_last;
            second_ff <= !pad_last;
         end
         if (load) begin
            round_ff <= '0;
         end else if (step) begin
            round_ff <= round_ff + 6'd1;
         end
         if (state_ff == sha_pkg::ST_FOLD) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + work[i];
            end
            idx_ff <= '0;
         end
         if (rsp_fire) begin
            idx_ff <= idx_ff + 2'd1;
            if (idx_ff == sha_pkg::LAST_IDX) begin
               chain_ff <= sha_pkg::INIT_HASH;
               count_ff <= '0;
               fin_ff <= 1'b0;
            end
         end
      end
   end

   // digest word select
   always_comb begin
      rsp_digest_word = {chain_ff[{idx_ff, 1'b0}], chain_ff[{idx_ff, 1'b1}]};
      rsp_word_index = idx_ff;
      rsp_last_word = (idx_ff == sha_pkg::LAST_IDX);
   end

endmodule

`default_nettype wire
